// File: design/anfs_pkg.sv
// ----------------------------------------------------------------------------
// anfs_pkg
// Shared types, constants and helpers of the Annex B NAL frame scanner.
// ----------------------------------------------------------------------------
package anfs_pkg;

    localparam int POS_W       = 24;
    localparam int OUT_W       = 24;
    localparam int TYPE_W      = 5;
    localparam int BYTE_W      = 8;
    localparam int CLASS_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TYPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER_TYPE = 2'd2;

    localparam logic [TYPE_W-1:0] KEY_TYPE_RST    = 5'd5;
    localparam logic [TYPE_W-1:0] SLICE_TYPE_RST  = 5'd1;
    localparam logic [TYPE_W-1:0] FILLER_TYPE_RST = 5'd12;

    localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_KEY  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_PRED = 2'd2;

    // One classified byte, handed from the front end to the back end.
    typedef struct packed {
        logic [TYPE_W-1:0] nal_type;
        logic              match4;
        logic [POS_W-1:0]  start4;
        logic              match3;
        logic [POS_W-1:0]  start3;
        logic              last;
        logic [POS_W-1:0]  len;
    } t_scan_item;

    function automatic logic [OUT_W-1:0] sat_out(input logic [POS_W-1:0] v);
        logic [POS_W+OUT_W-1:0] wide;
        logic [POS_W+OUT_W-1:0] lim;
        wide = {{OUT_W{1'b0}}, v};
        lim  = {{POS_W{1'b0}}, {OUT_W{1'b1}}};
        if (wide > lim) begin
            return {OUT_W{1'b1}};
        end
        return wide[OUT_W-1:0];
    endfunction

endpackage

// File: design/anfs_front.sv
// ----------------------------------------------------------------------------
// anfs_front
// Keeps the last four bytes and the byte position of the frame and flags
// three- and four-byte start codes for each accepted byte.
// ----------------------------------------------------------------------------
module anfs_front import anfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte_value,
    input  logic              i_last_byte,
    output t_scan_item        o_item
);

    logic [BYTE_W-1:0] r_recent [4];
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic              zero0;
    logic              zero1;
    logic              zero2;
    logic              one3;

    assign zero0 = (r_recent[0] == '0);
    assign zero1 = (r_recent[1] == '0);
    assign zero2 = (r_recent[2] == '0);
    assign one3  = (r_recent[3] == BYTE_W'(1));
    assign n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);

    always_comb begin
        o_item.nal_type = i_byte_value[TYPE_W-1:0];
        o_item.match4   = (r_pos >= POS_W'(4)) && zero0 && zero1 && zero2 && one3;
        o_item.start4   = r_pos - POS_W'(4);
        o_item.match3   = (r_pos >= POS_W'(3)) && zero1 && zero2 && one3;
        o_item.start3   = r_pos - POS_W'(3);
        o_item.last     = i_last_byte;
        o_item.len      = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_recent[k] <= '0;
            end
            r_pos <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                for (int k = 0; k < 4; k++) begin
                    r_recent[k] <= '0;
                end
                r_pos <= '0;
            end else begin
                r_recent[0] <= r_recent[1];
                r_recent[1] <= r_recent[2];
                r_recent[2] <= r_recent[3];
                r_recent[3] <= i_byte_value;
                r_pos       <= n_pos;
            end
        end
    end

endmodule

// File: design/anfs_queue.sv
// ----------------------------------------------------------------------------
// anfs_queue
// Short FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module anfs_queue import anfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_scan_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_scan_item o_item,
    input  logic       i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_scan_item       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: design/anfs_back.sv
// ----------------------------------------------------------------------------
// anfs_back
// Resolves start codes against the NAL type registers, tracks key, slice and
// filler findings, and registers the per-frame result.
// ----------------------------------------------------------------------------
module anfs_back import anfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TYPE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    input  t_scan_item           i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CLASS_W-1:0]   o_frame_class,
    output logic [OUT_W-1:0]     o_frame_bytes,
    output logic [OUT_W-1:0]     o_filler_bytes
);

    logic [TYPE_W-1:0]  r_key_type;
    logic [TYPE_W-1:0]  r_slice_type;
    logic [TYPE_W-1:0]  r_filler_type;
    logic               r_pend_valid;
    logic [TYPE_W-1:0]  r_pend_type;
    logic [POS_W-1:0]   r_pend_start;
    logic               r_key_seen;
    logic               r_slice_seen;
    logic               r_filler_found;
    logic [POS_W-1:0]   r_filler_start;
    logic               r_out_valid;
    logic [CLASS_W-1:0] r_frame_class;
    logic [OUT_W-1:0]   r_frame_bytes;
    logic [OUT_W-1:0]   r_filler_bytes;

    logic               n_key_seen;
    logic               n_slice_seen;
    logic               n_filler_found;
    logic [POS_W-1:0]   n_filler_start;
    logic [CLASS_W-1:0] n_frame_class;
    logic [OUT_W-1:0]   n_filler_bytes;

    assign o_pop          = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid    = r_out_valid;
    assign o_frame_class  = r_frame_class;
    assign o_frame_bytes  = r_frame_bytes;
    assign o_filler_bytes = r_filler_bytes;

    // The held three-byte match is older, so it is recorded before the
    // four-byte match of the current byte.
    always_comb begin
        n_key_seen     = r_key_seen;
        n_slice_seen   = r_slice_seen;
        n_filler_found = r_filler_found;
        n_filler_start = r_filler_start;
        if (r_pend_valid) begin
            if (r_pend_type == r_key_type) begin
                n_key_seen = 1'b1;
            end
            if (r_pend_type == r_slice_type) begin
                n_slice_seen = 1'b1;
            end
            if (r_pend_type == r_filler_type && !n_filler_found) begin
                n_filler_found = 1'b1;
                n_filler_start = r_pend_start;
            end
        end
        if (i_item.match4) begin
            if (i_item.nal_type == r_key_type) begin
                n_key_seen = 1'b1;
            end
            if (i_item.nal_type == r_slice_type) begin
                n_slice_seen = 1'b1;
            end
            if (i_item.nal_type == r_filler_type && !n_filler_found) begin
                n_filler_found = 1'b1;
                n_filler_start = i_item.start4;
            end
        end
        if (n_key_seen) begin
            n_frame_class = CLASS_KEY;
        end else if (n_slice_seen) begin
            n_frame_class = CLASS_PRED;
        end else begin
            n_frame_class = CLASS_NONE;
        end
        if (n_filler_found && (i_item.len > n_filler_start)) begin
            n_filler_bytes = sat_out(i_item.len - n_filler_start);
        end else begin
            n_filler_bytes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_type    <= KEY_TYPE_RST;
            r_slice_type  <= SLICE_TYPE_RST;
            r_filler_type <= FILLER_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_TYPE:    r_key_type    <= i_cfg_data;
                CFG_SLICE_TYPE:  r_slice_type  <= i_cfg_data;
                CFG_FILLER_TYPE: r_filler_type <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid   <= 1'b0;
            r_pend_type    <= '0;
            r_pend_start   <= '0;
            r_key_seen     <= 1'b0;
            r_slice_seen   <= 1'b0;
            r_filler_found <= 1'b0;
            r_filler_start <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_item.last) begin
                    r_pend_valid   <= 1'b0;
                    r_key_seen     <= 1'b0;
                    r_slice_seen   <= 1'b0;
                    r_filler_found <= 1'b0;
                    r_filler_start <= '0;
                end else begin
                    r_pend_valid   <= i_item.match3;
                    r_pend_type    <= i_item.nal_type;
                    r_pend_start   <= i_item.start3;
                    r_key_seen     <= n_key_seen;
                    r_slice_seen   <= n_slice_seen;
                    r_filler_found <= n_filler_found;
                    r_filler_start <= n_filler_start;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_frame_class  <= n_frame_class;
            r_frame_bytes  <= sat_out(i_item.len);
            r_filler_bytes <= n_filler_bytes;
        end
    end

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_frame_class != 2'd3))
        else $error("frame class out of range");

    a_filler_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_filler_bytes <= r_frame_bytes))
        else $error("filler count exceeds frame length");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=>
            (!r_pend_valid && !r_key_seen && !r_slice_seen && !r_filler_found))
        else $error("frame state not cleared after last byte");

    a_pend_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.last && i_item.match3) |=> r_pend_valid)
        else $error("three-byte match not held");

endmodule

// File: design/annexb_nal_frame_scanner.sv
// ----------------------------------------------------------------------------
// annexb_nal_frame_scanner
// Scans the bytes of one Annex B coded frame for start codes and reports the
// frame class, the frame length and the filler byte count at its last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock; only a report held under output stall
// stops the back end, and the input stalls once the two-entry queue fills.
// The last byte of a frame is written into the queue when it is accepted; the
// report is registered when the back end pops that byte from the queue.
// Reset (synchronous, active low) clears the frame state and the queue and
// loads the NAL type registers with 5, 1 and 12.
module annexb_nal_frame_scanner import anfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TYPE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_byte_value,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CLASS_W-1:0]   o_frame_class,
    output logic [OUT_W-1:0]     o_frame_bytes,
    output logic [OUT_W-1:0]     o_filler_bytes
);

    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic       in_accept;
    t_scan_item front_item;
    t_scan_item q_item;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    anfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_item       (front_item)
    );

    anfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    anfs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_class  (o_frame_class),
        .o_frame_bytes  (o_frame_bytes),
        .o_filler_bytes (o_filler_bytes)
    );

endmodule
